// ===== hdl/lcf_pkg.sv =====
// ----------------------------------------------------------------------------
// lcf_pkg
// Shared types and constants for the LED clock face controller.
// ----------------------------------------------------------------------------
`default_nettype none

package lcf_pkg;

  // ring and field sizes
  localparam int LED_COUNT  = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 32;

  // operating modes
  localparam logic [1:0] MODE_CLOCK    = 2'd0;
  localparam logic [1:0] MODE_DISPLAY  = 2'd1;
  localparam logic [1:0] MODE_SET_HOUR = 2'd2;
  localparam logic [1:0] MODE_SET_MIN  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SECOND   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_SECONDS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHOW_BLINKS        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_HALF_TICKS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BEEP_TICKS         = 3'd4;

  // time limits
  localparam logic [5:0] LAST_SECOND  = 6'd59;
  localparam logic [5:0] LAST_MINUTE  = 6'd59;
  localparam logic [3:0] LAST_HOUR    = 4'd11;
  localparam logic [5:0] MINUTE_STEP  = 6'd5;
  localparam logic [6:0] MINUTES_HOUR = 7'd60;
  localparam logic [3:0] PRESS_MAX    = 4'd15;

  typedef struct packed {
    logic [9:0] ticks_per_second;
    logic [3:0] long_press_seconds;
    logic [3:0] show_blinks;
    logic [7:0] blink_half_ticks;
    logic [7:0] beep_ticks;
  } cfg_t;

  typedef struct packed {
    logic [5:0]           minutes;
    logic [3:0]           hours;
    logic [1:0]           mode;
    logic                 buzzer;
    logic [LED_COUNT-1:0] leds;
  } result_t;

  // one-hot LED for a ring position, dark when out of range
  function automatic logic [LED_COUNT-1:0] led_bit(input logic [3:0] pos);
    logic [LED_COUNT-1:0] v;
    v = '0;
    if (pos < 4'(LED_COUNT)) begin
      v[pos] = 1'b1;
    end
    return v;
  endfunction

  // minutes / 5 by reciprocal multiply, exact for 0..59
  function automatic logic [3:0] minute_slot(input logic [5:0] m);
    logic [9:0] p;
    p = {4'd0, m} * 10'd13;
    return p[9:6];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/lcf_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// lcf_cfg_regs
// Configuration register file, written through the config channel.
// ----------------------------------------------------------------------------
`default_nettype none

module lcf_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           wr_en,
  input  wire logic [lcf_pkg::CFG_IDX_W-1:0]  wr_index,
  input  wire logic [lcf_pkg::CFG_DATA_W-1:0] wr_data,
  output lcf_pkg::cfg_t                       cfg
);
  import lcf_pkg::*;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ticks_per_second   <= 10'd10;
      cfg.long_press_seconds <= 4'd5;
      cfg.show_blinks        <= 4'd5;
      cfg.blink_half_ticks   <= 8'd3;
      cfg.beep_ticks         <= 8'd3;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_TICKS_PER_SECOND:   cfg.ticks_per_second   <= wr_data;
        REG_LONG_PRESS_SECONDS: cfg.long_press_seconds <= wr_data[3:0];
        REG_SHOW_BLINKS:        cfg.show_blinks        <= wr_data[3:0];
        REG_BLINK_HALF_TICKS:   cfg.blink_half_ticks   <= wr_data[7:0];
        REG_BEEP_TICKS:         cfg.beep_ticks         <= wr_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lcf_core.sv =====
// ----------------------------------------------------------------------------
// lcf_core
// Clock, press timing, display blinking and beep state with one-step update.
// ----------------------------------------------------------------------------
`default_nettype none

module lcf_core (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    step,
  input  wire logic    tick,
  input  wire logic    button,
  input  wire lcf_pkg::cfg_t cfg,
  output lcf_pkg::result_t result
);
  import lcf_pkg::*;

  logic [1:0] mode_reg,        mode_reg_next;
  logic [3:0] hours_count,     hours_count_next;
  logic [5:0] minutes_count,   minutes_count_next;
  logic [5:0] seconds_count,   seconds_count_next;
  logic [9:0] subsecond_ticks, subsecond_ticks_next;
  logic [3:0] press_seconds,   press_seconds_next;
  logic [9:0] press_ticks,     press_ticks_next;
  logic [7:0] blink_timer,     blink_timer_next;
  logic       blink_phase,     blink_phase_next;
  logic [3:0] blinks_left,     blinks_left_next;
  logic [7:0] beep_timer,      beep_timer_next;

  logic       sec_done;
  logic       press_sec_done;
  logic       press_long;
  logic [6:0] min_plus;
  logic [LED_COUNT-1:0] leds;

  assign sec_done       = ({1'b0, subsecond_ticks} + 11'd1) >= {1'b0, cfg.ticks_per_second};
  assign press_sec_done = ({1'b0, press_ticks} + 11'd1) >= {1'b0, cfg.ticks_per_second};
  assign press_long     = press_seconds >= cfg.long_press_seconds;
  assign min_plus       = {1'b0, minutes_count} + {1'b0, MINUTE_STEP};

  // next state for one item: tick work first, then the button
  always_comb begin
    mode_reg_next        = mode_reg;
    hours_count_next     = hours_count;
    minutes_count_next   = minutes_count;
    seconds_count_next   = seconds_count;
    subsecond_ticks_next = subsecond_ticks;
    press_seconds_next   = press_seconds;
    press_ticks_next     = press_ticks;
    blink_timer_next     = blink_timer;
    blink_phase_next     = blink_phase;
    blinks_left_next     = blinks_left;
    beep_timer_next      = beep_timer;

    if (tick) begin
      if (beep_timer != 8'd0) begin
        beep_timer_next = beep_timer - 8'd1;
      end
      if (mode_reg == MODE_DISPLAY) begin
        // blink sequencer
        if (blink_timer > 8'd1) begin
          blink_timer_next = blink_timer - 8'd1;
        end else if (blink_phase) begin
          blink_phase_next = 1'b0;
          blink_timer_next = cfg.blink_half_ticks;
        end else if (blinks_left <= 4'd1) begin
          blinks_left_next = 4'd0;
          blink_timer_next = 8'd0;
          mode_reg_next    = MODE_CLOCK;
        end else begin
          blinks_left_next = blinks_left - 4'd1;
          blink_phase_next = 1'b1;
          blink_timer_next = cfg.blink_half_ticks;
        end
      end else if (mode_reg == MODE_CLOCK) begin
        // time of day
        if (sec_done) begin
          subsecond_ticks_next = 10'd0;
          if (seconds_count >= LAST_SECOND) begin
            seconds_count_next = 6'd0;
            if (minutes_count >= LAST_MINUTE) begin
              minutes_count_next = 6'd0;
              hours_count_next   = (hours_count >= LAST_HOUR) ? 4'd0 : hours_count + 4'd1;
            end else begin
              minutes_count_next = minutes_count + 6'd1;
            end
          end else begin
            seconds_count_next = seconds_count + 6'd1;
          end
        end else begin
          subsecond_ticks_next = subsecond_ticks + 10'd1;
        end
      end
    end

    if (button) begin
      // press timing
      if (tick) begin
        if (press_sec_done) begin
          press_ticks_next = 10'd0;
          if (press_seconds < PRESS_MAX) begin
            press_seconds_next = press_seconds + 4'd1;
          end
        end else begin
          press_ticks_next = press_ticks + 10'd1;
        end
      end
    end else begin
      // release judges the press against the mode after tick work
      press_seconds_next = 4'd0;
      press_ticks_next   = 10'd0;
      if (press_seconds != 4'd0) begin
        unique case (mode_reg_next)
          MODE_CLOCK: begin
            if (press_long) begin
              beep_timer_next = cfg.beep_ticks;
              mode_reg_next   = MODE_SET_HOUR;
            end else begin
              mode_reg_next    = MODE_DISPLAY;
              blinks_left_next = cfg.show_blinks;
              blink_phase_next = 1'b1;
              blink_timer_next = cfg.blink_half_ticks;
            end
          end
          MODE_SET_HOUR: begin
            if (press_long) begin
              mode_reg_next = MODE_SET_MIN;
            end else begin
              hours_count_next = (hours_count_next >= LAST_HOUR) ? 4'd0
                                                                  : hours_count_next + 4'd1;
            end
          end
          MODE_SET_MIN: begin
            if (press_long) begin
              beep_timer_next = cfg.beep_ticks;
              mode_reg_next   = MODE_CLOCK;
            end else if (min_plus >= MINUTES_HOUR) begin
              minutes_count_next = 6'(min_plus - MINUTES_HOUR);
            end else begin
              minutes_count_next = min_plus[5:0];
            end
          end
          MODE_DISPLAY: ;
          default: ;
        endcase
      end
    end
  end

  // LED ring from the updated state
  always_comb begin
    unique case (mode_reg_next)
      MODE_DISPLAY:  leds = led_bit(hours_count_next)
                           | (blink_phase_next ? led_bit(minute_slot(minutes_count_next))
                                               : '0);
      MODE_SET_HOUR: leds = led_bit(hours_count_next);
      MODE_SET_MIN:  leds = led_bit(minute_slot(minutes_count_next));
      default:       leds = '0;
    endcase
  end

  assign result.leds    = leds;
  assign result.buzzer  = beep_timer_next != 8'd0;
  assign result.mode    = mode_reg_next;
  assign result.hours   = hours_count_next;
  assign result.minutes = minutes_count_next;

  // state registers, updated once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg        <= MODE_CLOCK;
      hours_count     <= 4'd7;
      minutes_count   <= 6'd30;
      seconds_count   <= 6'd0;
      subsecond_ticks <= 10'd0;
      press_seconds   <= 4'd0;
      press_ticks     <= 10'd0;
      blink_timer     <= 8'd0;
      blink_phase     <= 1'b0;
      blinks_left     <= 4'd0;
      beep_timer      <= 8'd0;
    end else if (step) begin
      mode_reg        <= mode_reg_next;
      hours_count     <= hours_count_next;
      minutes_count   <= minutes_count_next;
      seconds_count   <= seconds_count_next;
      subsecond_ticks <= subsecond_ticks_next;
      press_seconds   <= press_seconds_next;
      press_ticks     <= press_ticks_next;
      blink_timer     <= blink_timer_next;
      blink_phase     <= blink_phase_next;
      blinks_left     <= blinks_left_next;
      beep_timer      <= beep_timer_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/led_clock_face_controller.sv =====
// ----------------------------------------------------------------------------
// led_clock_face_controller
// Twelve-hour LED ring clock with button-driven display and time setting.
//
// Input stream: one transaction per sample, carrying the base tick flag and
// the button level. Output stream: one transaction per input, carrying the
// LED pattern, buzzer, mode and the current hours and minutes.
// Config channel: cfg_index selects a register, cfg_data is its value; it is
// always ready. The user must write it only while no transaction is in
// flight; the block itself does not enforce this. An accepted input sits
// in an input register; the state update and the result are computed from
// it in one pass and land in the output register. Throughput is one
// transaction per cycle while the receiver does not stall. When the
// receiver stalls, the result holds in the output register and one more
// input is taken into the input register before s_tready drops. Reset
// clears both valid flags and sets the state: clock mode, 7:30:00, no beep.
// ----------------------------------------------------------------------------
`default_nettype none

module led_clock_face_controller (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // input stream
  input  wire logic                           s_tvalid,
  output      logic                           s_tready,
  input  wire logic [lcf_pkg::IN_DATA_W-1:0]  s_tdata,  // tick, button
  // output stream
  output      logic                           m_tvalid,
  input  wire logic                           m_tready,
  output      logic [lcf_pkg::OUT_DATA_W-1:0] m_tdata,  // leds[11:0], buzzer, mode[1:0],
                                                        // hours[3:0], minutes[5:0]
  // config write channel
  input  wire logic                           cfg_valid,
  output      logic                           cfg_ready,
  input  wire logic [lcf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lcf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lcf_pkg::*;

  cfg_t    cfg;
  result_t next_result;
  result_t out_result;

  logic in_valid;
  logic in_tick;
  logic in_button;
  logic advance;

  assign cfg_ready = 1'b1;

  lcf_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // item moves on when the output register is free or being drained
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_tick   <= s_tdata[0];
      in_button <= s_tdata[1];
    end
  end

  lcf_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .tick   (in_tick),
    .button (in_button),
    .cfg    (cfg),
    .result (next_result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= next_result;
    end
  end

  assign m_tdata = {(OUT_DATA_W - $bits(result_t))'(0), out_result};

  // checks
  a_clock_dark: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_result.mode == MODE_CLOCK |-> out_result.leds == '0)
    else $error("leds lit in clock mode");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_result.hours <= LAST_HOUR && out_result.minutes <= LAST_MINUTE)
    else $error("time out of range");

  a_hour_shown: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (out_result.mode == MODE_DISPLAY || out_result.mode == MODE_SET_HOUR)
    |-> out_result.leds[out_result.hours])
    else $error("hour LED dark while shown");

  a_one_or_two_leds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $countones(out_result.leds) <= 2)
    else $error("too many LEDs lit");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && m_tvalid && !m_tready |-> !s_tready && !advance)
    else $error("input taken while both registers full");

endmodule

`default_nettype wire

// ===== tb/led_clock_face_controller_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_clock_face_controller_test
// Self-checking bench for the LED clock face controller. Tick and button
// samples go in over the input stream. A behavioral copy of the clock,
// display and setting logic predicts the result of every transaction. The
// output stream is compared field by field against those predictions. Runs
// a short directed table, then randomized press sequences under several
// register settings. A last part steps the time to 11:55 or later and lets
// it roll over the hour and the twelve-hour wrap.
// ----------------------------------------------------------------------------

module led_clock_face_controller_test;
  import lcf_pkg::*;

  localparam int LIMIT_CYCLES = 400000;

  // directed table row: reprogram to the fast setting first, sample, and
  // whether the expected face is written out by hand
  typedef struct packed {
    bit new_cfg;
    bit tick;
    bit button;
    bit typed;
  } row_t;

  // face right after reset: clock mode at 7:30, dark ring, quiet buzzer
  localparam result_t RESET_FACE = '{minutes: 6'd30, hours: 4'd7, mode: MODE_CLOCK,
                                     buzzer: 1'b0, leds: '0};
  // fast setting: one tick per second, two-second long press, one blink
  localparam cfg_t FAST_CFG = '{10'd1, 4'd2, 4'd1, 8'd1, 8'd1};

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // tick, button
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // leds[11:0], buzzer, mode[1:0], hours[3:0],
                                         // minutes[5:0]
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predicted face state and register copy
  cfg_t       face_cfg = '{10'd10, 4'd5, 4'd5, 8'd3, 8'd3};
  logic [1:0] face_mode = MODE_CLOCK;
  logic [3:0] face_hrs = 4'd7;
  logic [5:0] face_mins = 6'd30;
  logic [5:0] face_secs = '0;
  logic [9:0] sub_ticks = '0;
  logic [3:0] held_secs = '0;
  logic [9:0] held_ticks = '0;
  logic [7:0] blink_cnt = '0;
  logic       blink_lit = 1'b0;
  logic [3:0] blinks_to_go = '0;
  logic [7:0] beep_left = '0;

  result_t face_q[$];
  int      mismatch_count = 0;
  int      faces_checked = 0;
  int      samples_sent = 0;
  int      quiet_left = 0;
  int      ready_hold = 0;
  int      cycle_count = 0;

  row_t    directed [23];
  cfg_t    phase_cfg [7];
  int      phase_len [7];

  led_clock_face_controller uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on result %0d: %s got %0d expected %0d", faces_checked, what, got,
             want);
    mismatch_count++;
  endtask

  // advance the face by one sample and form the resulting output
  task automatic step_face(input bit tk, input bit bt, output result_t r);
    logic [3:0] held;
    bit         is_long;
    if (tk) begin
      if (beep_left != 0) beep_left--;
      if (face_mode == MODE_DISPLAY) begin
        // blink sequencing: on half, off half, then next blink or exit
        if (blink_cnt > 8'd1) begin
          blink_cnt--;
        end else if (blink_lit) begin
          blink_lit = 1'b0;
          blink_cnt = face_cfg.blink_half_ticks;
        end else if (blinks_to_go <= 4'd1) begin
          blinks_to_go = '0;
          blink_cnt = '0;
          face_mode = MODE_CLOCK;
        end else begin
          blinks_to_go--;
          blink_lit = 1'b1;
          blink_cnt = face_cfg.blink_half_ticks;
        end
      end else if (face_mode == MODE_CLOCK) begin
        // time of day runs only in clock mode
        if (int'(sub_ticks) + 1 >= int'(face_cfg.ticks_per_second)) begin
          sub_ticks = '0;
          if (face_secs >= LAST_SECOND) begin
            face_secs = '0;
            if (face_mins >= LAST_MINUTE) begin
              face_mins = '0;
              face_hrs = (face_hrs >= LAST_HOUR) ? 4'd0 : face_hrs + 4'd1;
            end else begin
              face_mins++;
            end
          end else begin
            face_secs++;
          end
        end else begin
          sub_ticks++;
        end
      end
    end

    // press timing, judged on release
    if (bt) begin
      if (tk) begin
        if (int'(held_ticks) + 1 >= int'(face_cfg.ticks_per_second)) begin
          held_ticks = '0;
          if (held_secs != PRESS_MAX) held_secs++;
        end else begin
          held_ticks++;
        end
      end
    end else begin
      held = held_secs;
      held_secs = '0;
      held_ticks = '0;
      if (held != 0 && face_mode != MODE_DISPLAY) begin
        is_long = (held >= face_cfg.long_press_seconds);
        case (face_mode)
          MODE_CLOCK: begin
            if (is_long) begin
              beep_left = face_cfg.beep_ticks;
              face_mode = MODE_SET_HOUR;
            end else begin
              face_mode = MODE_DISPLAY;
              blinks_to_go = face_cfg.show_blinks;
              blink_lit = 1'b1;
              blink_cnt = face_cfg.blink_half_ticks;
            end
          end
          MODE_SET_HOUR: begin
            if (is_long) face_mode = MODE_SET_MIN;
            else face_hrs = (face_hrs >= LAST_HOUR) ? 4'd0 : face_hrs + 4'd1;
          end
          default: begin
            if (is_long) begin
              beep_left = face_cfg.beep_ticks;
              face_mode = MODE_CLOCK;
            end else begin
              face_mins = 6'((7'(face_mins) + 7'(MINUTE_STEP)) % MINUTES_HOUR);
            end
          end
        endcase
      end
    end

    // ring pattern for the mode
    case (face_mode)
      MODE_DISPLAY: begin
        r.leds = 12'd1 << face_hrs;
        if (blink_lit) r.leds = r.leds | (12'd1 << (face_mins / 6'd5));
      end
      MODE_SET_HOUR: r.leds = 12'd1 << face_hrs;
      MODE_SET_MIN:  r.leds = 12'd1 << (face_mins / 6'd5);
      default:       r.leds = '0;
    endcase
    r.buzzer = (beep_left != 0);
    r.mode = face_mode;
    r.hours = face_hrs;
    r.minutes = face_mins;
  endtask

  // one input transaction with a random lead-in gap, then its prediction
  task automatic send_sample(input bit tk, input bit bt, input bit typed);
    result_t want;
    int      gap;
    int      r;
    r = $urandom_range(0, 99);
    if (quiet_left > 0) begin
      quiet_left--;
      gap = 0;
    end else if (r < 3) begin
      quiet_left = $urandom_range(20, 60);
      gap = 0;
    end else if (r < 50) begin
      gap = 0;
    end else if (r < 85) begin
      gap = $urandom_range(1, 3);
    end else if (r < 97) begin
      gap = $urandom_range(4, 10);
    end else begin
      gap = $urandom_range(20, 40);
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(IN_DATA_W-2){1'b0}}, bt, tk};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    step_face(tk, bt, want);
    if (typed) want = RESET_FACE;
    face_q.push_back(want);
    samples_sent++;
  endtask

  // hold the input side until every predicted result has come back
  task automatic flush_faces();
    if (face_q.size() != 0) begin
      s_tvalid <= 1'b0;
      while (face_q.size() != 0) @(posedge clk);
    end
  endtask

  // program all five registers while the block is idle
  task automatic apply_setting(input cfg_t c);
    logic [CFG_IDX_W-1:0]  ids [5];
    logic [CFG_DATA_W-1:0] vals [5];
    ids[0] = REG_TICKS_PER_SECOND;   vals[0] = c.ticks_per_second;
    ids[1] = REG_LONG_PRESS_SECONDS; vals[1] = CFG_DATA_W'(c.long_press_seconds);
    ids[2] = REG_SHOW_BLINKS;        vals[2] = CFG_DATA_W'(c.show_blinks);
    ids[3] = REG_BLINK_HALF_TICKS;   vals[3] = CFG_DATA_W'(c.blink_half_ticks);
    ids[4] = REG_BEEP_TICKS;         vals[4] = CFG_DATA_W'(c.beep_ticks);
    flush_faces();
    repeat (4) @(posedge clk);
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= ids[i];
      cfg_data <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    face_cfg = c;
  endtask

  // press held for a number of whole seconds plus a fraction, then released
  task automatic press_run(input int secs);
    int teff;
    int need;
    int counted;
    bit tk;
    teff = (face_cfg.ticks_per_second == 0) ? 1 : int'(face_cfg.ticks_per_second);
    need = secs * teff + $urandom_range(0, ((teff > 40) ? 40 : teff) - 1);
    counted = 0;
    send_sample(1'b0, 1'b1, 1'b0);
    while (counted < need) begin
      tk = ($urandom_range(0, 3) != 0);
      send_sample(tk, 1'b1, 1'b0);
      counted += tk;
    end
    send_sample($urandom_range(0, 1), 1'b0, 1'b0);
  endtask

  // mostly well-formed presses of short, long and saturating length,
  // mixed with idle ticks and raw noise
  task automatic random_phase(input int count);
    int stop;
    int secs;
    int lp;
    int teff;
    int c;
    stop = samples_sent + count;
    while (samples_sent < stop) begin
      if ($urandom_range(0, 49) == 0) flush_faces();
      if ($urandom_range(0, 9) < 7) begin
        teff = (face_cfg.ticks_per_second == 0) ? 1 : int'(face_cfg.ticks_per_second);
        lp = (face_cfg.long_press_seconds == 0) ? 1 : int'(face_cfg.long_press_seconds);
        c = $urandom_range(0, 9);
        if (c == 0) secs = 0;
        else if (c < 6) secs = $urandom_range(1, (lp > 1) ? lp - 1 : 1);
        else if (c < 9) secs = $urandom_range(lp, lp + 1);
        else secs = $urandom_range(15, 16);
        if (secs * teff > 200) secs = 200 / teff;
        press_run(secs);
        repeat ($urandom_range(0, 6)) send_sample($urandom_range(0, 4) != 0, 1'b0, 1'b0);
      end else begin
        repeat ($urandom_range(1, 6)) send_sample($urandom_range(0, 1), $urandom_range(0, 1),
                                                  1'b0);
      end
    end
  endtask

  // output side stalls: long ready stretches and short or long stalls
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (!m_tready) begin
      m_tready <= 1'b1;
      ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                 : $urandom_range(0, 12);
    end else begin
      m_tready <= 1'b0;
      ready_hold <= ($urandom_range(0, 14) == 0) ? $urandom_range(15, 40)
                                                  : $urandom_range(0, 2);
    end
  end

  // compare each output transaction with the oldest prediction
  always @(posedge clk) begin : face_check
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata[$bits(result_t)-1:0]);
      if (face_q.size() == 0) begin
        report_mismatch("result with nothing expected, leds", got.leds, 0);
      end else begin
        want = face_q.pop_front();
        if (got.leds != want.leds) report_mismatch("leds", got.leds, want.leds);
        if (got.buzzer != want.buzzer) report_mismatch("buzzer", got.buzzer, want.buzzer);
        if (got.mode != want.mode) report_mismatch("mode", got.mode, want.mode);
        if (got.hours != want.hours) report_mismatch("hours", got.hours, want.hours);
        if (got.minutes != want.minutes) report_mismatch("minutes", got.minutes,
                                                         want.minutes);
      end
      faces_checked++;
    end
  end

  // stimulus
  initial begin
    // reset face, short press to display, release ignored during display,
    // display end, long press into hour setting, hour step, minute setting,
    // five-minute step, long press back to clock with a beep
    directed = '{
      '{1'b0, 1'b0, 1'b0, 1'b1}, '{1'b0, 1'b1, 1'b0, 1'b1}, '{1'b0, 1'b0, 1'b1, 1'b1},
      '{1'b0, 1'b0, 1'b0, 1'b1}, '{1'b1, 1'b1, 1'b1, 1'b0}, '{1'b0, 1'b0, 1'b0, 1'b0},
      '{1'b0, 1'b1, 1'b1, 1'b0}, '{1'b0, 1'b0, 1'b0, 1'b0}, '{1'b0, 1'b1, 1'b0, 1'b0},
      '{1'b0, 1'b1, 1'b1, 1'b0}, '{1'b0, 1'b1, 1'b1, 1'b0}, '{1'b0, 1'b0, 1'b0, 1'b0},
      '{1'b0, 1'b1, 1'b1, 1'b0}, '{1'b0, 1'b0, 1'b0, 1'b0}, '{1'b0, 1'b1, 1'b1, 1'b0},
      '{1'b0, 1'b1, 1'b1, 1'b0}, '{1'b0, 1'b0, 1'b0, 1'b0}, '{1'b0, 1'b1, 1'b1, 1'b0},
      '{1'b0, 1'b0, 1'b0, 1'b0}, '{1'b0, 1'b1, 1'b1, 1'b0}, '{1'b0, 1'b1, 1'b1, 1'b0},
      '{1'b0, 1'b0, 1'b0, 1'b0}, '{1'b0, 1'b1, 1'b0, 1'b0}
    };

    // register settings per random phase, extremes included
    phase_cfg[0] = '{10'd1, 4'd2, 4'd2, 8'd1, 8'd2};
    phase_cfg[1] = '{10'd0, 4'd0, 4'd0, 8'd0, 8'd0};
    phase_cfg[2] = '{10'd2, 4'd15, 4'd15, 8'd255, 8'd255};
    phase_cfg[3] = '{10'd1023, 4'd1, 4'd1, 8'd2, 8'd1};
    phase_cfg[4] = '{10'd3, 4'd3, 4'd3, 8'd5, 8'd7};
    phase_cfg[5] = '{10'($urandom_range(1, 4)), 4'($urandom_range(1, 6)),
                     4'($urandom_range(0, 15)), 8'($urandom_range(1, 8)),
                     8'($urandom_range(0, 255))};
    phase_cfg[6] = '{10'd10, 4'd5, 4'd5, 8'd3, 8'd3};
    phase_len = '{30, 20, 25, 15, 30, 30, 20};

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (directed[i]) begin
      if (directed[i].new_cfg) apply_setting(FAST_CFG);
      send_sample(directed[i].tick, directed[i].button, directed[i].typed);
    end

    // random phases
    for (int p = 0; p < 7; p++) begin
      apply_setting(phase_cfg[p]);
      random_phase(phase_len[p]);
    end

    // steer the time to 11:55 or later, then run it over the hour and the wrap
    apply_setting(FAST_CFG);
    send_sample(1'b0, 1'b0, 1'b0);
    while (face_mode != MODE_CLOCK) begin
      if (face_mode == MODE_DISPLAY) send_sample(1'b1, 1'b0, 1'b0);
      else press_run(2);
    end
    press_run(2);
    while (face_hrs != LAST_HOUR) press_run(1);
    press_run(2);
    while (face_mins < 6'd55) press_run(1);
    press_run(2);
    while (face_hrs == LAST_HOUR) send_sample(1'b1, 1'b0, 1'b0);

    // drain and settle
    flush_faces();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
